FILE: src/silfc_pkg.sv
`default_nettype none

package silfc_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned LEVEL_W  = 33;
  localparam int unsigned COST_W   = 63;

  localparam logic [COST_W-1:0] COST_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EVAL = 4'b0010,
    ST_SIFT = 4'b0100,
    ST_OUT  = 4'b1000
  } core_state_t;

  typedef enum logic [3:0] {
    SF_IDLE = 4'b0001,
    SF_DOWN = 4'b0010,
    SF_UPST = 4'b0100,
    SF_UP   = 4'b1000
  } sift_state_t;

  typedef struct packed {
    logic start;
    logic replace;
  } sift_cmd_t;

  typedef struct packed {
    logic done;
  } sift_sts_t;

endpackage

`default_nettype wire

FILE: src/silfc_ram.sv
`default_nettype none

module silfc_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_a_addr,
  output logic      [WIDTH-1:0]         rd_a_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_b_addr,
  output logic      [WIDTH-1:0]         rd_b_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

`default_nettype wire

FILE: src/silfc_sifter.sv
`default_nettype none

module silfc_sifter #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire silfc_pkg::sift_cmd_t                cmd,
  input  wire logic signed [silfc_pkg::LEVEL_W-1:0] x,
  input  wire logic [$clog2(DEPTH+1)-1:0]          size,
  output silfc_pkg::sift_sts_t                     sts,
  output logic signed [silfc_pkg::LEVEL_W-1:0]     top_level
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = silfc_pkg::LEVEL_W;

  silfc_pkg::sift_state_t state_r, state_nxt;
  logic [AW-1:0]        i_r, i_nxt;
  logic [AW-1:0]        p_r, p_nxt;
  logic [AW-1:0]        l_idx_r, l_idx_nxt;
  logic [AW-1:0]        r_idx_r, r_idx_nxt;
  logic                 l_ok_r, l_ok_nxt;
  logic                 r_ok_r, r_ok_nxt;
  logic signed [LW-1:0] x_r, x_nxt;
  logic [CW-1:0]        size_r, size_nxt;
  logic signed [LW-1:0] top_r;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [LW-1:0] wr_data;
  logic [AW-1:0] rd_a_addr;
  logic [AW-1:0] rd_b_addr;
  logic [LW-1:0] rd_a_data;
  logic [LW-1:0] rd_b_data;

  logic                 issue;
  logic [AW-1:0]        node;
  logic [AW+1:0]        l_ext;
  logic [AW+1:0]        r_ext;
  logic                 take_l;
  logic                 take_r;
  logic signed [LW-1:0] cand;
  logic [AW-1:0]        up_p;
  logic                 done_c;

  silfc_ram #(
    .WIDTH(LW),
    .DEPTH(DEPTH)
  ) u_heap (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_a_addr(rd_a_addr),
    .rd_a_data(rd_a_data),
    .rd_b_addr(rd_b_addr),
    .rd_b_data(rd_b_data)
  );

  assign take_l = l_ok_r && ($signed(rd_a_data) > x_r);
  assign cand   = take_l ? $signed(rd_a_data) : x_r;
  assign take_r = r_ok_r && ($signed(rd_b_data) > cand);

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    p_nxt     = p_r;
    x_nxt     = x_r;
    size_nxt  = size_r;
    l_ok_nxt  = l_ok_r;
    r_ok_nxt  = r_ok_r;
    l_idx_nxt = l_idx_r;
    r_idx_nxt = r_idx_r;
    wr_en     = 1'b0;
    wr_addr   = i_r;
    wr_data   = x_r;
    rd_a_addr = l_idx_r;
    rd_b_addr = r_idx_r;
    done_c    = 1'b0;
    issue     = 1'b0;
    node      = i_r;
    up_p      = '0;

    unique case (state_r)
      silfc_pkg::SF_IDLE: begin
        if (cmd.start) begin
          x_nxt    = x;
          size_nxt = size;
          if (cmd.replace) begin
            node      = '0;
            i_nxt     = '0;
            issue     = 1'b1;
            state_nxt = silfc_pkg::SF_DOWN;
          end else begin
            i_nxt     = AW'(size);
            state_nxt = silfc_pkg::SF_UPST;
          end
        end
      end
      silfc_pkg::SF_DOWN: begin
        wr_en = 1'b1;
        if (take_r) begin
          wr_data = rd_b_data;
          node    = r_idx_r;
          i_nxt   = r_idx_r;
          issue   = 1'b1;
        end else if (take_l) begin
          wr_data = rd_a_data;
          node    = l_idx_r;
          i_nxt   = l_idx_r;
          issue   = 1'b1;
        end else begin
          wr_data   = x_r;
          i_nxt     = AW'(size_r);
          state_nxt = silfc_pkg::SF_UPST;
        end
      end
      silfc_pkg::SF_UPST: begin
        if (i_r == '0) begin
          wr_en     = 1'b1;
          wr_addr   = '0;
          wr_data   = x_r;
          done_c    = 1'b1;
          state_nxt = silfc_pkg::SF_IDLE;
        end else begin
          up_p      = (i_r - AW'(1)) >> 1;
          rd_a_addr = up_p;
          p_nxt     = up_p;
          state_nxt = silfc_pkg::SF_UP;
        end
      end
      silfc_pkg::SF_UP: begin
        wr_en = 1'b1;
        if ($signed(rd_a_data) >= x_r) begin
          wr_data   = x_r;
          done_c    = 1'b1;
          state_nxt = silfc_pkg::SF_IDLE;
        end else begin
          wr_data = rd_a_data;
          i_nxt   = p_r;
          if (p_r == '0) begin
            state_nxt = silfc_pkg::SF_UPST;
          end else begin
            up_p      = (p_r - AW'(1)) >> 1;
            rd_a_addr = up_p;
            p_nxt     = up_p;
          end
        end
      end
      default: begin
        state_nxt = silfc_pkg::SF_IDLE;
      end
    endcase

    l_ext = {1'b0, node, 1'b1};
    r_ext = l_ext + (AW+2)'(1);
    if (issue) begin
      rd_a_addr = l_ext[AW-1:0];
      rd_b_addr = r_ext[AW-1:0];
      l_idx_nxt = l_ext[AW-1:0];
      r_idx_nxt = r_ext[AW-1:0];
      l_ok_nxt  = l_ext < (AW+2)'(size_nxt);
      r_ok_nxt  = r_ext < (AW+2)'(size_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= silfc_pkg::SF_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    i_r     <= i_nxt;
    p_r     <= p_nxt;
    x_r     <= x_nxt;
    size_r  <= size_nxt;
    l_ok_r  <= l_ok_nxt;
    r_ok_r  <= r_ok_nxt;
    l_idx_r <= l_idx_nxt;
    r_idx_r <= r_idx_nxt;
    if (wr_en && (wr_addr == '0)) begin
      top_r <= $signed(wr_data);
    end
  end

  assign sts.done  = done_c;
  assign top_level = top_r;

endmodule

`default_nettype wire

FILE: src/strict_increasing_l1_fit_cost_core.sv
// Running minimum L1 cost of a strictly increasing fit, one result transaction per input
// transaction. Each sample has its position in the current run subtracted and then updates
// a max-heap of breakpoints held in one RAM of HEAP_DEPTH entries; tuser high on an input
// transaction starts a new run. One item is worked on at a time: it is evaluated, then the
// sifter visits each heap level of the sift-down (on a replace) and of the sift-up in turn,
// and the result is registered for output; the heap RAM moves one level per cycle.
// The heap needs no clearing after reset, since only entries below the fill count are read.
// Once a run holds HEAP_DEPTH items, further items are ignored and flagged in out_tuser.
`default_nettype none

module strict_increasing_l1_fit_cost_core #(
  parameter int unsigned HEAP_DEPTH = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [31:0]  in_tdata,   // sample[31:0]
  input  wire logic         in_tuser,   // first
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic      [95:0]  out_tdata,  // total_cost[62:0], fit_level[95:63]
  output logic              out_tuser   // overflow
);

  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned LW = silfc_pkg::LEVEL_W;
  localparam int unsigned KW = silfc_pkg::COST_W;
  localparam int unsigned SW = silfc_pkg::SAMPLE_W;

  silfc_pkg::core_state_t state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [KW-1:0]        cost_r, cost_nxt;
  logic [SW-1:0]        sample_r, sample_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [KW-1:0]        out_cost_r, out_cost_nxt;
  logic signed [LW-1:0] out_level_r, out_level_nxt;
  logic                 out_ovf_r, out_ovf_nxt;

  silfc_pkg::sift_cmd_t cmd;
  silfc_pkg::sift_sts_t sts;
  logic signed [LW-1:0] top_level;
  logic signed [LW-1:0] v_c;
  logic [LW:0]          d_c;
  logic [KW:0]          sum_c;
  logic [KW-1:0]        cost_add_c;
  logic                 replace_c;

  silfc_sifter #(
    .DEPTH(HEAP_DEPTH)
  ) u_sifter (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .x        (v_c),
    .size     (count_r),
    .sts      (sts),
    .top_level(top_level)
  );

  assign v_c        = $signed({sample_r[SW-1], sample_r}) - $signed(LW'(count_r));
  assign d_c        = $signed({top_level[LW-1], top_level}) - $signed({v_c[LW-1], v_c});
  assign sum_c      = {1'b0, cost_r} + (KW+1)'(d_c);
  assign cost_add_c = sum_c[KW] ? silfc_pkg::COST_MAX : sum_c[KW-1:0];
  assign replace_c  = (count_r != '0) && (top_level > v_c);

  assign in_tready  = (state_r == silfc_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_level_r, out_cost_r};
  assign out_tuser  = out_ovf_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cost_nxt      = cost_r;
    sample_nxt    = sample_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_cost_nxt  = out_cost_r;
    out_level_nxt = out_level_r;
    out_ovf_nxt   = out_ovf_r;
    cmd.start     = 1'b0;
    cmd.replace   = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      silfc_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          sample_nxt = in_tdata[SW-1:0];
          if (in_tuser) begin
            count_nxt = '0;
            cost_nxt  = '0;
          end
          state_nxt = silfc_pkg::ST_EVAL;
        end
      end
      silfc_pkg::ST_EVAL: begin
        if (count_r >= CW'(HEAP_DEPTH)) begin
          ovf_nxt   = 1'b1;
          state_nxt = silfc_pkg::ST_OUT;
        end else begin
          ovf_nxt     = 1'b0;
          cmd.start   = 1'b1;
          cmd.replace = replace_c;
          if (replace_c) begin
            cost_nxt = cost_add_c;
          end
          state_nxt = silfc_pkg::ST_SIFT;
        end
      end
      silfc_pkg::ST_SIFT: begin
        if (sts.done) begin
          count_nxt = count_r + CW'(1);
          state_nxt = silfc_pkg::ST_OUT;
        end
      end
      silfc_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_cost_nxt  = cost_r;
          out_level_nxt = top_level;
          out_ovf_nxt   = ovf_r;
          state_nxt     = silfc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = silfc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= silfc_pkg::ST_IDLE;
      count_r     <= '0;
      cost_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cost_r      <= cost_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sample_r    <= sample_nxt;
    ovf_r       <= ovf_nxt;
    out_cost_r  <= out_cost_nxt;
    out_level_r <= out_level_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

endmodule

`default_nettype wire

FILE: src/silfc_checker.sv
`default_nettype none

module silfc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [95:0] out_tdata,
  input wire logic        out_tuser
);

  // A stalled result transaction keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result transaction changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

  // Only one item is worked on at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in progress");

  // A result never appears in the cycle right after an input transaction.
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared too early");

endmodule

bind strict_increasing_l1_fit_cost_core silfc_checker u_silfc_checker (.*);

`default_nettype wire
